FILE: src/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;

  // Fixed-point format of coefficients and roots
  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;               // coefficient width
  localparam int TOLW      = 16;               // tolerance register width

  // Discriminant and square root
  localparam int DW        = 2 * CW + 2;       // magnitude of a non-negative discriminant
  localparam int SQ_N      = DW / 2;           // one root bit per cell
  localparam int RTW       = SQ_N;             // root width
  localparam int RMW       = RTW + 2;          // partial remainder width

  // Division
  localparam int NW        = CW + 3;           // signed numerator -b -+ s
  localparam int UNW       = NW - 1;           // numerator magnitude
  localparam int UDW       = CW + 1;           // denominator magnitude
  localparam int DVW       = UNW + FRAC_BITS;  // dividend width, one quotient bit per cell

  // Root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef enum logic [2:0] {
    K_NONE,
    K_INF,
    K_LIN,
    K_ONE,
    K_TWO
  } kind_e;

  // Travels alongside the square-root cells
  typedef struct packed {
    kind_e                 kind;
    logic                  a_neg;
    logic signed [CW:0]    nb;    // -b, or -c for the linear case
    logic signed [CW+1:0]  den;   // 2a, or b for the linear case
    logic [DW-1:0]         d;     // discriminant, zero unless two roots
  } sq_meta_t;

  // Travels alongside the divider cells
  typedef struct packed {
    kind_e            kind;
    logic             a_neg;
    logic [UDW-1:0]   ud;
    logic             neg1;
    logic             neg2;
    logic [DVW-1:0]   dvd1;
    logic [DVW-1:0]   dvd2;
  } dv_meta_t;

  // Signed quotient with saturation; bit CW is the overflow flag
  function automatic logic [CW:0] sat_quot(input logic [DVW-1:0] q, input logic neg);
    logic [DVW-1:0] lim;
    logic [DVW-1:0] nq;
    lim = DVW'(1) << (CW - 1);
    nq  = '0 - q;
    if (neg) begin
      if (q > lim) return {1'b1, 1'b1, {(CW-1){1'b0}}};
      return {1'b0, nq[CW-1:0]};
    end
    if (q >= lim) return {1'b1, 1'b0, {(CW-1){1'b1}}};
    return {1'b0, q[CW-1:0]};
  endfunction

endpackage

FILE: src/qrs_in_if.sv
`timescale 1ns / 1ps
interface qrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

FILE: src/qrs_out_if.sv
`timescale 1ns / 1ps
interface qrs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         num_roots;
  logic signed [31:0] first_root;
  logic signed [31:0] second_root;
  logic               overflow;

  modport source (output valid, output num_roots, output first_root, output second_root,
                  output overflow, input ready);
  modport sink   (input valid, input num_roots, input first_root, input second_root,
                  input overflow, output ready);
endinterface

FILE: src/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
// One step of a restoring integer square root: brings in two bits of the radicand
module qrs_sqrt_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [1:0]                bits_i,
  input  logic [qrs_pkg::RMW-1:0]   rem_i,
  input  logic [qrs_pkg::RTW-1:0]   root_i,
  output logic [qrs_pkg::RMW-1:0]   rem_o,
  output logic [qrs_pkg::RTW-1:0]   root_o
);
  import qrs_pkg::*;

  logic [RMW+1:0] cat;
  logic [RMW+1:0] trial;
  logic [RMW+1:0] diff;
  logic           ge;
  logic [RMW-1:0] rem_d;
  logic [RTW-1:0] root_d;

  // trial subtract of 4*root+1
  always_comb begin
    cat    = {rem_i, bits_i};
    trial  = {1'b0, root_i, 2'b01};
    diff   = cat - trial;
    ge     = (cat >= trial);
    rem_d  = ge ? diff[RMW-1:0] : cat[RMW-1:0];
    root_d = {root_i[RTW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end
endmodule

FILE: src/qrs_div_cell.sv
`timescale 1ns / 1ps
// One step of restoring division: brings in one dividend bit, yields one quotient bit
module qrs_div_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      bit_i,
  input  logic [qrs_pkg::UDW-1:0]   ud_i,
  input  logic [qrs_pkg::UDW-1:0]   rem_i,
  input  logic [qrs_pkg::DVW-1:0]   q_i,
  output logic [qrs_pkg::UDW-1:0]   rem_o,
  output logic [qrs_pkg::DVW-1:0]   q_o
);
  import qrs_pkg::*;

  logic [UDW:0]   cat;
  logic [UDW:0]   diff;
  logic           ge;
  logic [UDW-1:0] rem_d;
  logic [DVW-1:0] q_d;

  always_comb begin
    cat   = {rem_i, bit_i};
    diff  = cat - {1'b0, ud_i};
    ge    = (cat >= {1'b0, ud_i});
    rem_d = ge ? diff[UDW-1:0] : cat[UDW-1:0];
    q_d   = {q_i[DVW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      q_o   <= q_d;
    end
  end
endmodule

FILE: src/quadratic_root_solver_top.sv
`timescale 1ns / 1ps
// Real roots of a*x^2 + b*x + c = 0 on signed Q16.16 coefficients.
// coef_i: valid/ready channel carrying coef_a, coef_b, coef_c; a transfer
//   happens on a rising edge with valid and ready both high.
// root_o: valid/ready channel carrying num_roots (0 none, 1 one, 2 two,
//   3 infinitely many), first_root (smaller or only), second_root and
//   overflow (a root saturated). Unused roots read as zero.
// cfg_we_i/cfg_wdata_i write zero_tolerance; write only while idle.
// Throughput: one equation per cycle while root_o is not stalled. The path runs
//   through the 33-cell square-root chain and the two 50-cell divider chains,
//   plus input, multiply, classify, numerator and output registers.
// When root_o stalls, the whole chain holds and coef_i.ready drops; results
//   are never lost or repeated.
// Reset clears all valid bits and sets zero_tolerance to 1.
module quadratic_root_solver_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  qrs_in_if.sink       coef_i,
  qrs_out_if.source    root_o
);
  import qrs_pkg::*;

  localparam int NVLD = 2 + (SQ_N + 1) + (DVW + 1);

  function automatic logic [CW:0] mag32(input logic signed [CW-1:0] v);
    logic signed [CW:0] e;
    e = {v[CW-1], v};
    return e[CW] ? (-e) : e;
  endfunction

  logic              en;
  logic [TOLW-1:0]   tol_q;
  logic [TOLW-1:0]   tol_eff;
  logic [NVLD-1:0]   vld_q;
  logic              out_v_q;

  // Tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOLW'(1);
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end
  assign tol_eff = (tol_q == '0) ? TOLW'(1) : tol_q;

  // Global advance: the chain moves unless a result waits unaccepted
  assign en           = !out_v_q || root_o.ready;
  assign coef_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[NVLD-2:0], coef_i.valid};
      out_v_q <= vld_q[NVLD-1];
    end
  end

  // Input register
  logic signed [CW-1:0] a0_q, b0_q, c0_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q <= coef_i.coef_a;
      b0_q <= coef_i.coef_b;
      c0_q <= coef_i.coef_c;
    end
  end

  // Products and near-zero flags
  logic [2*CW-1:0]        bb1_q;
  logic signed [2*CW-1:0] ac1_q;
  logic signed [CW-1:0]   a1_q, b1_q, c1_q;
  logic                   az1_q, bz1_q, cz1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      bb1_q <= $unsigned((2*CW)'(b0_q) * (2*CW)'(b0_q));
      ac1_q <= a0_q * c0_q;
      a1_q  <= a0_q;
      b1_q  <= b0_q;
      c1_q  <= c0_q;
      az1_q <= mag32(a0_q) < {{(CW+1-TOLW){1'b0}}, tol_eff};
      bz1_q <= mag32(b0_q) < {{(CW+1-TOLW){1'b0}}, tol_eff};
      cz1_q <= mag32(c0_q) < {{(CW+1-TOLW){1'b0}}, tol_eff};
    end
  end

  // Discriminant and case selection
  logic signed [DW:0] disc;
  logic [DW:0]        thr;
  sq_meta_t           sq_in;
  always_comb begin
    disc = $signed({1'b0, 2'b00, bb1_q}) - ($signed({{3{ac1_q[2*CW-1]}}, ac1_q}) <<< 2);
    thr  = (DW+1)'(tol_eff) << FRAC_BITS;
    if (az1_q) begin
      if (!bz1_q)     sq_in.kind = K_LIN;
      else if (cz1_q) sq_in.kind = K_INF;
      else            sq_in.kind = K_NONE;
    end else if (disc[DW]) begin
      sq_in.kind = K_NONE;
    end else if ($unsigned(disc) < thr) begin
      sq_in.kind = K_ONE;
    end else begin
      sq_in.kind = K_TWO;
    end
    sq_in.a_neg = a1_q[CW-1];
    sq_in.nb    = az1_q ? -{c1_q[CW-1], c1_q} : -{b1_q[CW-1], b1_q};
    sq_in.den   = az1_q ? {{2{b1_q[CW-1]}}, b1_q} : {a1_q[CW-1], a1_q, 1'b0};
    sq_in.d     = (sq_in.kind == K_TWO) ? disc[DW-1:0] : '0;
  end

  // Square-root chain
  sq_meta_t        sq_m_q [SQ_N+1];
  logic [RMW-1:0]  rem_c  [SQ_N+1];
  logic [RTW-1:0]  root_c [SQ_N+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_m_q[0] <= sq_in;
      for (int k = 0; k < SQ_N; k++) sq_m_q[k+1] <= sq_m_q[k];
    end
  end

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .bits_i (sq_m_q[k].d[2*(SQ_N-1-k)+1 : 2*(SQ_N-1-k)]),
      .rem_i  (rem_c[k]),
      .root_i (root_c[k]),
      .rem_o  (rem_c[k+1]),
      .root_o (root_c[k+1])
    );
  end

  // Numerators, magnitudes and signs
  dv_meta_t            dv_in;
  logic signed [NW-1:0] n1, n2, sx, nbx;
  logic signed [CW+1:0] dn;
  always_comb begin
    nbx          = {{2{sq_m_q[SQ_N].nb[CW]}}, sq_m_q[SQ_N].nb};
    sx           = {2'b00, root_c[SQ_N]};
    n1           = nbx - sx;
    n2           = nbx + sx;
    dn           = sq_m_q[SQ_N].den;
    dv_in.kind   = sq_m_q[SQ_N].kind;
    dv_in.a_neg  = sq_m_q[SQ_N].a_neg;
    dv_in.ud     = dn[CW+1] ? UDW'(-dn) : UDW'(dn);
    dv_in.neg1   = n1[NW-1] ^ dn[CW+1];
    dv_in.neg2   = n2[NW-1] ^ dn[CW+1];
    dv_in.dvd1   = {(n1[NW-1] ? UNW'(-n1) : UNW'(n1)), {FRAC_BITS{1'b0}}};
    dv_in.dvd2   = {(n2[NW-1] ? UNW'(-n2) : UNW'(n2)), {FRAC_BITS{1'b0}}};
  end

  // Divider chains, two lanes
  dv_meta_t        dv_m_q [DVW+1];
  logic [UDW-1:0]  r1_c [DVW+1];
  logic [UDW-1:0]  r2_c [DVW+1];
  logic [DVW-1:0]  q1_c [DVW+1];
  logic [DVW-1:0]  q2_c [DVW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_m_q[0] <= dv_in;
      for (int j = 0; j < DVW; j++) dv_m_q[j+1] <= dv_m_q[j];
    end
  end

  assign r1_c[0] = '0;
  assign r2_c[0] = '0;
  assign q1_c[0] = '0;
  assign q2_c[0] = '0;

  for (genvar j = 0; j < DVW; j++) begin : g_dv
    qrs_div_cell u_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .bit_i (dv_m_q[j].dvd1[DVW-1-j]),
      .ud_i  (dv_m_q[j].ud),
      .rem_i (r1_c[j]),
      .q_i   (q1_c[j]),
      .rem_o (r1_c[j+1]),
      .q_o   (q1_c[j+1])
    );
    qrs_div_cell u_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .bit_i (dv_m_q[j].dvd2[DVW-1-j]),
      .ud_i  (dv_m_q[j].ud),
      .rem_i (r2_c[j]),
      .q_i   (q2_c[j]),
      .rem_o (r2_c[j+1]),
      .q_o   (q2_c[j+1])
    );
  end

  // Saturation, ordering and result assembly
  logic [CW:0]    s1, s2;
  logic [1:0]     cnt_d;
  logic [CW-1:0]  r1_d, r2_d;
  logic           ovf_d;
  always_comb begin
    s1    = sat_quot(q1_c[DVW], dv_m_q[DVW].neg1);
    s2    = sat_quot(q2_c[DVW], dv_m_q[DVW].neg2);
    cnt_d = CNT_NONE;
    r1_d  = '0;
    r2_d  = '0;
    ovf_d = 1'b0;
    unique case (dv_m_q[DVW].kind)
      K_NONE: cnt_d = CNT_NONE;
      K_INF:  cnt_d = CNT_INF;
      K_LIN, K_ONE: begin
        cnt_d = CNT_ONE;
        r1_d  = s1[CW-1:0];
        ovf_d = s1[CW];
      end
      K_TWO: begin
        cnt_d = CNT_TWO;
        r1_d  = dv_m_q[DVW].a_neg ? s2[CW-1:0] : s1[CW-1:0];
        r2_d  = dv_m_q[DVW].a_neg ? s1[CW-1:0] : s2[CW-1:0];
        ovf_d = s1[CW] | s2[CW];
      end
      default: cnt_d = CNT_NONE;
    endcase
  end

  // Output register
  logic [1:0]    cnt_q;
  logic [CW-1:0] r1_q, r2_q;
  logic          ovf_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cnt_q <= cnt_d;
      r1_q  <= r1_d;
      r2_q  <= r2_d;
      ovf_q <= ovf_d;
    end
  end

  assign root_o.valid       = out_v_q;
  assign root_o.num_roots   = cnt_q;
  assign root_o.first_root  = r1_q;
  assign root_o.second_root = r2_q;
  assign root_o.overflow    = ovf_q;
endmodule

FILE: dv/tb_quadratic_root_solver_top.sv
`timescale 1ns / 1ps
module tb_quadratic_root_solver_top;
  import qrs_pkg::*;

  localparam int LATENCY   = 88;
  localparam int WDOG_MAX  = 20000;
  localparam int HOLD_LEN  = 300;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } coef_t;

  typedef struct packed {
    logic [1:0]         cnt;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic               ovf;
  } roots_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  qrs_in_if  coef_bus ();
  qrs_out_if root_bus ();

  quadratic_root_solver_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_i      (coef_bus.sink),
    .root_o      (root_bus.source)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Shared state
  coef_t  pending_q[$];
  roots_t expected_roots_q[$];
  logic [15:0] tol_model;
  int  src_idle_pct;
  int  dst_idle_pct;
  bit  hold_req;
  int  hold_left;
  int  mismatches;
  int  wdog;
  bit  stim_done;

  // Predictor: magnitude below tolerance counts as zero
  function automatic bit is_zero(input logic signed [66:0] v, input logic [15:0] tol);
    logic [66:0] m;
    logic [16:0] t;
    m = v[66] ? -v : v;
    t = (tol == 0) ? 17'd1 : {1'b0, tol};
    return m < t;
  endfunction

  // Signed fixed-point quotient with saturation
  function automatic logic [31:0] fx_quot(input logic signed [66:0] num,
                                          input logic signed [66:0] den,
                                          inout logic ovf);
    logic [127:0] un;
    logic [127:0] ud;
    logic [127:0] q;
    bit neg;
    un  = num[66] ? 128'(-num) : 128'(num);
    ud  = den[66] ? 128'(-den) : 128'(den);
    neg = num[66] ^ den[66];
    q   = (un << FRAC_BITS) / ud;
    if (neg) begin
      if (q > 128'h8000_0000) begin
        ovf = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  // Floor square root of a non-negative discriminant
  function automatic logic [33:0] floor_sqrt(input logic [67:0] d);
    logic [35:0] rem;
    logic [35:0] trial;
    logic [33:0] root;
    rem  = '0;
    root = '0;
    for (int i = 33; i >= 0; i--) begin
      rem   = (rem << 2) | 36'(d[2*i +: 2]);
      trial = 36'({root, 2'b01});
      root  = root << 1;
      if (rem >= trial) begin
        rem     = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root;
  endfunction

  function automatic roots_t solve_roots(input coef_t e, input logic [15:0] tol);
    roots_t r;
    logic signed [66:0] a, b, c, s;
    logic signed [67:0] disc;
    logic [67:0] thr;
    logic ovf;
    logic [31:0] lo_r, hi_r;
    a = e.a;
    b = e.b;
    c = e.c;
    ovf = 1'b0;
    r = '0;
    if (is_zero(a, tol)) begin
      if (!is_zero(b, tol)) begin
        r.r1  = fx_quot(-c, b, ovf);
        r.cnt = CNT_ONE;
      end else if (is_zero(c, tol)) begin
        r.cnt = CNT_INF;
      end else begin
        r.cnt = CNT_NONE;
      end
    end else begin
      disc = 68'(b * b) - 68'(4 * a * c);
      thr  = 68'((tol == 0) ? 17'd1 : {1'b0, tol}) << FRAC_BITS;
      if (disc < 0) begin
        r.cnt = CNT_NONE;
      end else if (68'(disc) < thr) begin
        r.r1  = fx_quot(-b, 2 * a, ovf);
        r.cnt = CNT_ONE;
      end else begin
        s    = 67'(floor_sqrt(68'(disc)));
        lo_r = fx_quot(-b - s, 2 * a, ovf);
        hi_r = fx_quot(-b + s, 2 * a, ovf);
        r.r1 = a[66] ? hi_r : lo_r;
        r.r2 = a[66] ? lo_r : hi_r;
        r.cnt = CNT_TWO;
      end
    end
    r.ovf = ovf;
    return r;
  endfunction

  // Driver: sender offers items from the queue, idling at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_bus.valid  <= 1'b0;
      coef_bus.coef_a <= '0;
      coef_bus.coef_b <= '0;
      coef_bus.coef_c <= '0;
    end else begin
      if (coef_bus.valid && coef_bus.ready) begin
        expected_roots_q.push_back(solve_roots(pending_q.pop_front(), tol_model));
      end
      if ((!coef_bus.valid || coef_bus.ready) ) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          coef_bus.valid  <= 1'b1;
          coef_bus.coef_a <= pending_q[0].a;
          coef_bus.coef_b <= pending_q[0].b;
          coef_bus.coef_c <= pending_q[0].c;
        end else begin
          coef_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_bus.ready <= 1'b0;
      hold_left      <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left      <= HOLD_LEN;
      root_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      root_bus.ready <= (hold_left == 1);
    end else begin
      root_bus.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    roots_t want;
    if (rst_ni && root_bus.valid && root_bus.ready) begin
      if (expected_roots_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("Unexpected result cnt=%0d r1=%h r2=%h ovf=%0d",
          root_bus.num_roots, root_bus.first_root, root_bus.second_root, root_bus.overflow);
      end else begin
        want = expected_roots_q.pop_front();
        if (root_bus.num_roots !== want.cnt || root_bus.first_root !== want.r1 ||
            root_bus.second_root !== want.r2 || root_bus.overflow !== want.ovf) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("Mismatch exp cnt=%0d r1=%h r2=%h ovf=%0d got cnt=%0d r1=%h r2=%h ovf=%0d",
              want.cnt, want.r1, want.r2, want.ovf, root_bus.num_roots,
              root_bus.first_root, root_bus.second_root, root_bus.overflow);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((coef_bus.valid && coef_bus.ready) || (root_bus.valid && root_bus.ready) || !rst_ni)
      wdog <= 0;
    else if (!stim_done) begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coef(input int mode);
    case (mode)
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      2:       return 32'($signed($urandom_range(0, 8)) - 4);
      default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  task automatic add_item(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    coef_t e;
    e.a = a;
    e.b = b;
    e.c = c;
    pending_q.push_back(e);
  endtask

  // Random equations, mostly well-scaled, some with integer roots
  task automatic add_random(input int n);
    int r1, r2, k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        r1 = $signed($urandom_range(0, 40)) - 20;
        r2 = $urandom_range(1) ? r1 : $signed($urandom_range(0, 40)) - 20;
        k  = $signed($urandom_range(1, 4)) * ($urandom_range(1) ? 1 : -1);
        add_item(32'(k * 65536), 32'(-k * (r1 + r2) * 65536), 32'(k * r1 * r2 * 65536));
      end else begin
        add_item(rand_coef($urandom_range(3)), rand_coef($urandom_range(3)),
                 rand_coef($urandom_range(3)));
      end
    end
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !coef_bus.valid);
    wait (expected_roots_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic set_tol(input logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    tol_model   <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    tol_model    = 16'd1;
    src_idle_pct = 33;
    dst_idle_pct = 70;
    hold_req     = 1'b0;
    mismatches   = 0;
    wdog         = 0;
    stim_done    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: linear, degenerate, double root, saturation, extremes
    add_item(0, 0, 0);
    add_item(0, 0, 32'h0001_0000);
    add_item(0, 32'h0002_0000, 32'h0004_0000);
    add_item(0, 1, 32'h7FFF_FFFF);
    add_item(0, 32'hFFFF_FFFF, 32'h8000_0000);
    add_item(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
    add_item(32'h0001_0000, 0, 32'hFFFF_0000);
    add_item(32'hFFFF_0000, 0, 32'h0001_0000);
    add_item(32'h0001_0000, 0, 32'h0001_0000);
    add_item(1, 32'h7FFF_FFFF, 32'h8000_0000);
    add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    add_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_item(1, 0, 1);
    add_item(1, 2, 1);
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(32'h0001_0000, 32'h0000_0001, 0);
    drain();

    // Tolerance zero behaves as one
    set_tol(16'd0);
    add_item(0, 0, 0);
    add_item(0, 1, 32'h0001_0000);
    add_random(60);

    // Hold-off: receiver stalls while sender keeps offering
    hold_req = 1'b1;
    add_random(40);
    drain();
    hold_req = 1'b0;

    set_tol(16'hFFFF);
    add_item(32'h0000_FFFE, 32'h0000_FFFF, 32'h0001_0000);
    add_item(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
    add_random(110);
    drain();

    src_idle_pct = 70;
    dst_idle_pct = 33;
    set_tol(16'd1);
    add_random(120);
    drain();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    set_tol(16'd300);
    add_random(120);
    drain();

    stim_done = 1'b1;
    if (mismatches == 0 && expected_roots_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
src/qrs_pkg.sv
src/qrs_in_if.sv
src/qrs_out_if.sv
src/qrs_sqrt_cell.sv
src/qrs_div_cell.sv
src/quadratic_root_solver_top.sv
dv/tb_quadratic_root_solver_top.sv
